// ===== hw/rtl/sql_tokenizer_defines.svh =====
// assertion macros for the sql tokenizer
`ifndef SQL_TOKENIZER_DEFINES_SVH
`define SQL_TOKENIZER_DEFINES_SVH
`ifndef SYNTHESIS
`define SQLT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SQLT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SQLT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SQLT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/sqlt_pkg.sv =====
`timescale 1ns / 1ps
package sqlt_pkg;

    localparam logic [30:0] IntMax = 31'h7FFF_FFFF;

    typedef enum logic [3:0] {
        M_IDLE, M_DASH, M_COMMENT, M_LT, M_GT, M_BANG, M_STR, M_STRESC,
        M_INT, M_DOT, M_FRAC, M_IDENT, M_IDDOT, M_IDSEG
    } scan_mode_t;

    localparam logic [4:0] K_PLUS = 5'd0, K_MINUS = 5'd1, K_STAR = 5'd2,
        K_SLASH = 5'd3, K_EQ = 5'd4, K_NE2 = 5'd5, K_NE = 5'd6, K_LT = 5'd7,
        K_GT = 5'd8, K_LE = 5'd9, K_GE = 5'd10, K_LPAR = 5'd11,
        K_RPAR = 5'd12, K_COMMA = 5'd13, K_SEMI = 5'd14, K_STRING = 5'd15,
        K_INT = 5'd16, K_REAL = 5'd17, K_IDENT = 5'd18, K_KEYWORD = 5'd19,
        K_END = 5'd20;

    localparam logic [2:0] E_NONE = 3'd0, E_UNTERM = 3'd1, E_NUMBER = 3'd2,
        E_CHAR = 3'd3, E_SAT = 3'd4;

    typedef struct packed {
        logic [4:0]  kind;
        logic [4:0]  kw;
        logic [15:0] start;
        logic [15:0] len;
        logic [30:0] ival;
        logic [2:0]  err;
    } token_t;

    // per-item result group from scanner to output queue
    typedef struct packed {
        logic [1:0] count;
        token_t     t0;
        token_t     t1;
        token_t     t2;
    } burst_t;

    function automatic logic [47:0] kw_word(input logic [4:0] id);
        logic [47:0] w;
        w = '0;
        unique case (id)
            5'd1:  w = {"tceles"};
            5'd2:  w = {32'd0, "sa"};
            5'd3:  w = {16'd0, "morf"};
            5'd4:  w = {16'd0, "nioj"};
            5'd5:  w = {32'd0, "no"};
            5'd6:  w = {8'd0, "erehw"};
            5'd7:  w = {16'd0, "eurt"};
            5'd8:  w = {8'd0, "eslaf"};
            5'd9:  w = {8'd0, "puorg"};
            5'd10: w = {32'd0, "yb"};
            5'd11: w = {8'd0, "redro"};
            5'd12: w = {24'd0, "csa"};
            5'd13: w = {16'd0, "csed"};
            5'd14: w = {32'd0, "ni"};
            5'd15: w = {"tesffo"};
            5'd16: w = {8'd0, "timil"};
            5'd17: w = {24'd0, "dna"};
            5'd18: w = {32'd0, "ro"};
            5'd19: w = {24'd0, "ton"};
            5'd20: w = {16'd0, "ekil"};
            5'd21: w = {32'd0, "si"};
            5'd22: w = {16'd0, "llun"};
            5'd23: w = {16'd0, "htiw"};
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [2:0] kw_len(input logic [4:0] id);
        logic [2:0] n;
        unique case (id)
            5'd2, 5'd5, 5'd10, 5'd14, 5'd18, 5'd21: n = 3'd2;
            5'd12, 5'd17, 5'd19: n = 3'd3;
            5'd3, 5'd4, 5'd7, 5'd13, 5'd20, 5'd22, 5'd23: n = 3'd4;
            5'd6, 5'd8, 5'd9, 5'd11, 5'd16: n = 3'd5;
            5'd1, 5'd15: n = 3'd6;
            default: n = 3'd7;
        endcase
        return n;
    endfunction

endpackage

// ===== hw/rtl/sqlt_scan.sv =====
`timescale 1ns / 1ps
module sqlt_scan import sqlt_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] char_code,
    input  logic       end_of_text,
    output burst_t     burst
);
    `include "sql_tokenizer_defines.svh"

    scan_mode_t  mode_reg, mode_next;
    logic        quote_reg, quote_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] tstart_reg, tstart_next;
    logic [30:0] acc_reg, acc_next;
    logic        sat_reg, sat_next;
    logic [47:0] kbuf_reg, kbuf_next;
    logic [2:0]  klen_reg, klen_next;
    logic        kimp_reg, kimp_next;

    logic [4:0]  kw_id;
    logic [34:0] acc_x10;
    logic [35:0] acc_sum;
    logic        c_dig, c_alpha, c_idch, c_space;
    logic [7:0]  c_low;
    logic        rescan;
    token_t      tk [3];
    logic [1:0]  cnt;

    assign c_dig   = char_code >= "0" && char_code <= "9";
    assign c_alpha = (char_code >= "a" && char_code <= "z") ||
                     (char_code >= "A" && char_code <= "Z");
    assign c_idch  = c_dig || c_alpha || char_code == "_";
    assign c_space = char_code == " " || char_code == 8'h09 || char_code == 8'h0A ||
                     char_code == 8'h0D || char_code == 8'h0C;
    assign c_low   = (char_code >= "A" && char_code <= "Z") ? char_code + 8'd32 : char_code;
    assign acc_x10 = {1'b0, acc_reg, 3'b0} + {3'b0, acc_reg, 1'b0};
    assign acc_sum = {1'b0, acc_x10} + {28'd0, char_code - 8'd48};

    // keyword match against the buffered lower-case text
    always_comb
    begin
        kw_id = '0;
        for (int k = 1; k <= 23; k++)
        begin
            if (!kimp_reg && kw_len(5'(k)) == klen_reg && kw_word(5'(k)) == kbuf_reg)
                kw_id = 5'(k);
        end
    end

    function automatic token_t mk(input logic [4:0] kind, input logic [15:0] start,
                                  input logic [15:0] len, input logic [2:0] err);
        token_t t;
        t = '0;
        t.kind = kind;
        t.start = start;
        t.len = len;
        t.err = err;
        return t;
    endfunction

    always_comb
    begin
        token_t pend;
        logic   have;
        logic [15:0] sp;
        pend = '0;
        have = 1'b0;
        rescan = 1'b0;
        sp = pos_reg - tstart_reg;
        mode_next = mode_reg;
        quote_next = quote_reg;
        tstart_next = tstart_reg;
        acc_next = acc_reg;
        sat_next = sat_reg;
        kbuf_next = kbuf_reg;
        klen_next = klen_reg;
        kimp_next = kimp_reg;
        pos_next = pos_reg + 16'd1;
        for (int i = 0; i < 3; i++) tk[i] = '0;
        cnt = '0;

        // first pass: the pending token, or a flush at end of text
        unique case (mode_reg)
            M_DASH:  begin have = 1'b1; pend = mk(K_MINUS, tstart_reg, 16'd1, E_NONE); end
            M_LT:    begin have = 1'b1; pend = mk(K_LT, tstart_reg, 16'd1, E_NONE); end
            M_GT:    begin have = 1'b1; pend = mk(K_GT, tstart_reg, 16'd1, E_NONE); end
            M_BANG:  begin have = 1'b1; pend = mk(K_PLUS, tstart_reg, 16'd1, E_CHAR); end
            M_STR, M_STRESC:
                     begin have = 1'b1; pend = mk(K_STRING, tstart_reg, sp, E_UNTERM); end
            M_INT:   begin
                have = 1'b1;
                pend = mk(K_INT, tstart_reg, sp, sat_reg ? E_SAT : E_NONE);
                pend.ival = acc_reg;
            end
            M_DOT:   begin have = 1'b1; pend = mk(K_REAL, tstart_reg, sp, E_NUMBER); end
            M_FRAC:  begin have = 1'b1; pend = mk(K_REAL, tstart_reg, sp, E_NONE); end
            M_IDENT, M_IDDOT, M_IDSEG:
                begin
                    have = 1'b1;
                    pend = mk(kw_id != 5'd0 ? K_KEYWORD : K_IDENT, tstart_reg, sp, E_NONE);
                    pend.kw = kw_id;
                end
            default: have = 1'b0;
        endcase

        if (end_of_text)
        begin
            if (have)
            begin
                tk[0] = pend;
                tk[1] = mk(K_END, pos_reg, 16'd0, E_NONE);
                cnt = 2'd2;
            end
            else
            begin
                tk[0] = mk(K_END, pos_reg, 16'd0, E_NONE);
                cnt = 2'd1;
            end
            mode_next = M_IDLE; quote_next = 1'b0; pos_next = '0; tstart_next = '0;
            acc_next = '0; sat_next = 1'b0; kbuf_next = '0; klen_next = '0; kimp_next = 1'b0;
        end
        else
        begin
            unique case (mode_reg)
                M_IDLE:    rescan = 1'b1;
                M_DASH:
                    if (char_code == "-") mode_next = M_COMMENT;
                    else rescan = 1'b1;
                M_COMMENT: if (char_code == 8'h0A) mode_next = M_IDLE;
                M_LT:
                    if (char_code == "=")
                    begin tk[0] = mk(K_LE, tstart_reg, 16'd2, E_NONE); cnt = 2'd1; mode_next = M_IDLE; end
                    else if (char_code == ">")
                    begin tk[0] = mk(K_NE2, tstart_reg, 16'd2, E_NONE); cnt = 2'd1; mode_next = M_IDLE; end
                    else rescan = 1'b1;
                M_GT:
                    if (char_code == "=")
                    begin tk[0] = mk(K_GE, tstart_reg, 16'd2, E_NONE); cnt = 2'd1; mode_next = M_IDLE; end
                    else rescan = 1'b1;
                M_BANG:
                    if (char_code == "=")
                    begin tk[0] = mk(K_NE, tstart_reg, 16'd2, E_NONE); cnt = 2'd1; mode_next = M_IDLE; end
                    else rescan = 1'b1;
                M_STR:
                    if (char_code == "\\") mode_next = M_STRESC;
                    else if (char_code == (quote_reg ? 8'h22 : 8'h27))
                    begin
                        tk[0] = mk(K_STRING, tstart_reg, sp, E_NONE);
                        cnt = 2'd1;
                        mode_next = M_IDLE;
                    end
                M_STRESC: mode_next = M_STR;
                M_INT:
                    if (c_dig)
                    begin
                        if (acc_sum > {5'd0, IntMax})
                        begin acc_next = IntMax; sat_next = 1'b1; end
                        else acc_next = acc_sum[30:0];
                    end
                    else if (char_code == ".") mode_next = M_DOT;
                    else rescan = 1'b1;
                M_DOT:
                    if (c_dig) mode_next = M_FRAC;
                    else rescan = 1'b1;
                M_FRAC:    if (!c_dig) rescan = 1'b1;
                M_IDENT:
                    if (c_idch)
                    begin
                        if (klen_reg >= 3'd6) kimp_next = 1'b1;
                        else
                        begin
                            kbuf_next = kbuf_reg | (48'(c_low) << {klen_reg, 3'b0});
                            klen_next = klen_reg + 3'd1;
                        end
                    end
                    else if (char_code == ".")
                    begin kimp_next = 1'b1; mode_next = M_IDDOT; end
                    else rescan = 1'b1;
                M_IDDOT:
                    if (char_code == "*")
                    begin
                        tk[0] = pend;
                        tk[0].len = sp + 16'd1;
                        cnt = 2'd1;
                        mode_next = M_IDLE;
                    end
                    else if (c_idch) mode_next = M_IDSEG;
                    else rescan = 1'b1;
                M_IDSEG:   if (!c_idch) rescan = 1'b1;
                default:   rescan = 1'b1;
            endcase

            // scan from idle, after emitting the pending token if any
            if (rescan)
            begin
                logic [1:0] n;
                n = 2'd0;
                if (mode_reg != M_IDLE && have)
                begin
                    tk[0] = pend;
                    n = 2'd1;
                end
                mode_next = M_IDLE;
                if (!c_space)
                begin
                    tstart_next = pos_reg;
                    unique case (1'b1)
                        char_code == "-": mode_next = M_DASH;
                        char_code == "<": mode_next = M_LT;
                        char_code == ">": mode_next = M_GT;
                        char_code == "!": mode_next = M_BANG;
                        char_code == 8'h27 || char_code == 8'h22:
                        begin
                            quote_next = char_code == 8'h22;
                            tstart_next = pos_reg + 16'd1;
                            mode_next = M_STR;
                        end
                        c_dig:
                        begin
                            acc_next = {23'd0, char_code - 8'd48};
                            sat_next = 1'b0;
                            mode_next = M_INT;
                        end
                        c_alpha:
                        begin
                            kbuf_next = {40'd0, c_low};
                            klen_next = 3'd1;
                            kimp_next = 1'b0;
                            mode_next = M_IDENT;
                        end
                        default:
                        begin
                            token_t s;
                            s = mk(K_PLUS, pos_reg, 16'd1, E_CHAR);
                            priority case (char_code)
                                "+": s.err = E_NONE;
                                "*": begin s.kind = K_STAR;  s.err = E_NONE; end
                                "/": begin s.kind = K_SLASH; s.err = E_NONE; end
                                "=": begin s.kind = K_EQ;    s.err = E_NONE; end
                                "(": begin s.kind = K_LPAR;  s.err = E_NONE; end
                                ")": begin s.kind = K_RPAR;  s.err = E_NONE; end
                                ",": begin s.kind = K_COMMA; s.err = E_NONE; end
                                ";": begin s.kind = K_SEMI;  s.err = E_NONE; end
                                default: s.err = E_CHAR;
                            endcase
                            tk[n] = s;
                            n = n + 2'd1;
                        end
                    endcase
                end
                cnt = n;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE; quote_reg <= 1'b0; pos_reg <= '0; tstart_reg <= '0;
            acc_reg <= '0; sat_reg <= 1'b0; kbuf_reg <= '0; klen_reg <= '0; kimp_reg <= 1'b0;
        end
        else if (step)
        begin
            mode_reg <= mode_next; quote_reg <= quote_next; pos_reg <= pos_next;
            tstart_reg <= tstart_next; acc_reg <= acc_next; sat_reg <= sat_next;
            kbuf_reg <= kbuf_next; klen_reg <= klen_next; kimp_reg <= kimp_next;
        end
    end

    assign burst.count = cnt;
    assign burst.t0 = tk[0];
    assign burst.t1 = tk[1];
    assign burst.t2 = tk[2];

    `SQLT_ASSERT_NXT(a_eot_clears, clk, rst_n, step && end_of_text, pos_reg == 16'd0 && mode_reg == M_IDLE)
    `SQLT_ASSERT_IMP(a_eot_count, clk, rst_n, end_of_text, cnt != 2'd0)
    `SQLT_ASSERT_IMP(a_klen_max, clk, rst_n, 1'b1, klen_reg <= 3'd6)
endmodule

// ===== hw/rtl/sqlt_outq.sv =====
`timescale 1ns / 1ps
module sqlt_outq import sqlt_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr,
    input  burst_t      burst,
    output logic        room,
    output logic        out_valid,
    input  logic        out_stall,
    output token_t      out_tok,
    output logic        out_last
);
    `include "sql_tokenizer_defines.svh"

    // 4-entry circular queue, up to two tokens per item and last marks
    token_t      q_reg [4];
    logic [3:0]  lst_reg;
    logic [1:0]  rd_reg, wr_reg;
    logic [2:0]  fill_reg, fill_next;
    logic        pop;
    logic [1:0]  nin;

    assign pop = out_valid && !out_stall;
    assign nin = wr ? burst.count : 2'd0;
    assign room = fill_reg <= 3'd2;
    assign out_valid = fill_reg != 3'd0;
    assign out_tok = q_reg[rd_reg];
    assign out_last = lst_reg[rd_reg];
    assign fill_next = fill_reg + {1'b0, nin} - {2'b0, pop};

    always_ff @(posedge clk)
    begin
        if (nin != 2'd0)
        begin
            q_reg[wr_reg] <= burst.t0;
            if (nin >= 2'd2) q_reg[wr_reg + 2'd1] <= burst.t1;
            if (nin == 2'd3) q_reg[wr_reg + 2'd2] <= burst.t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg <= '0; wr_reg <= '0; fill_reg <= '0; lst_reg <= '0;
        end
        else
        begin
            if (nin != 2'd0)
            begin
                lst_reg[wr_reg] <= nin == 2'd1;
                if (nin >= 2'd2) lst_reg[wr_reg + 2'd1] <= nin == 2'd2;
                if (nin == 2'd3) lst_reg[wr_reg + 2'd2] <= 1'b1;
            end
            wr_reg <= wr_reg + nin;
            rd_reg <= rd_reg + {1'b0, pop};
            fill_reg <= fill_next;
        end
    end

    `SQLT_ASSERT_IMP(a_no_overflow, clk, rst_n, 1'b1, fill_reg <= 3'd4)
    `SQLT_ASSERT_IMP(a_room_ok, clk, rst_n, wr, room)
    `SQLT_ASSERT_IMP(a_valid_fill, clk, rst_n, out_valid, fill_reg != 3'd0)
endmodule

// ===== hw/rtl/sql_tokenizer.sv =====
`timescale 1ns / 1ps
// channel | direction | handshake           | payload
// input   | in        | in_valid / in_stall | char_code, end_of_text
// output  | out       | out_valid/out_stall | token fields, last_of_run
//
// one byte is accepted per cycle while the output queue has room for two tokens
// an item causes at most two tokens; they are written into the output queue when the item is accepted
// the output queue drains one token per cycle while out_stall is low, so double results briefly stall
// reset (rst_n, async) returns the scanner to offset 0 and empties the queue
// in_stall rises whenever the queue holds more than two tokens
module sql_tokenizer import sqlt_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_code,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  token_kind,
    output logic [4:0]  keyword_id,
    output logic [15:0] start_offset,
    output logic [15:0] token_length,
    output logic [30:0] integer_value,
    output logic [2:0]  error_code,
    output logic        last_of_run
);
    burst_t burst;
    token_t tok;
    logic   room, step;

    // accept only with space for a full burst
    assign in_stall = !room;
    assign step = in_valid && room;

    sqlt_scan u_scan (
        .clk(clk), .rst_n(rst_n), .step(step),
        .char_code(char_code), .end_of_text(end_of_text), .burst(burst)
    );

    sqlt_outq u_outq (
        .clk(clk), .rst_n(rst_n), .wr(step), .burst(burst), .room(room),
        .out_valid(out_valid), .out_stall(out_stall), .out_tok(tok), .out_last(last_of_run)
    );

    assign token_kind = tok.kind;
    assign keyword_id = tok.kw;
    assign start_offset = tok.start;
    assign token_length = tok.len;
    assign integer_value = tok.ival;
    assign error_code = tok.err;
endmodule
